// ===== hdl/pfde_pkg.sv =====
// Shared types and constants for the Playfair digraph encryption block.
package pfde_pkg;

    localparam int SQUARE_DIM = 5;
    localparam int NUM_REGS   = 5;

    typedef logic [4:0] letter_t;
    typedef logic [2:0] pos_t;
    typedef logic [2:0] reg_index_t;
    typedef logic [24:0] row_t;

    // row, column, letter bits: square[r][c] is the cell, column 0 in low bits
    typedef logic [SQUARE_DIM-1:0][SQUARE_DIM-1:0][4:0] square_t;

    localparam letter_t LETTER_I   = 5'd8;
    localparam letter_t LETTER_J   = 5'd9;
    localparam letter_t LETTER_MAX = 5'd25;

    localparam reg_index_t REG_ROW_ZERO  = 3'd0;
    localparam reg_index_t REG_ROW_ONE   = 3'd1;
    localparam reg_index_t REG_ROW_TWO   = 3'd2;
    localparam reg_index_t REG_ROW_THREE = 3'd3;
    localparam reg_index_t REG_ROW_FOUR  = 3'd4;

    // default square A B C D E / F G H I K / L M N O P / Q R S T U / V W X Y Z
    localparam row_t ROW_ZERO_RESET  = 25'd4294688;
    localparam row_t ROW_ONE_RESET   = 25'd10755269;
    localparam row_t ROW_TWO_RESET   = 25'd16201099;
    localparam row_t ROW_THREE_RESET = 25'd21613104;
    localparam row_t ROW_FOUR_RESET  = 25'd27025109;

    typedef struct packed {
        letter_t first_letter;
        letter_t second_letter;
        logic    last_pair;
    } in_t;

    typedef struct packed {
        letter_t first_cipher;
        letter_t second_cipher;
        logic    letter_missing;
        logic    last_out;
    } out_t;

    // where a lane found its letter
    typedef struct packed {
        logic found;
        pos_t row;
        pos_t col;
    } loc_t;

endpackage

// ===== hdl/pfde_lane.sv =====
// Search lane: finds one letter in the key square with 25 parallel compares.
module pfde_lane
    import pfde_pkg::*;
(
    input  letter_t letter,
    input  square_t square,
    output loc_t    loc
);

    always_comb
    begin
        letter_t key;
        key = (letter == LETTER_J) ? LETTER_I : letter;
        loc = '0;
        if (key <= LETTER_MAX)
        begin
            // later cells overwrite earlier ones: last row-major hit wins
            for (int r = 0; r < SQUARE_DIM; r++)
            begin
                for (int c = 0; c < SQUARE_DIM; c++)
                begin
                    if (square[r][c] == key)
                    begin
                        loc.found = 1'b1;
                        loc.row   = 3'(r);
                        loc.col   = 3'(c);
                    end
                end
            end
        end
    end

endmodule

// ===== hdl/pfde_merge.sv =====
// Merge stage: applies the row, column or rectangle rule to both lane results.
module pfde_merge
    import pfde_pkg::*;
(
    input  loc_t    loc_a,
    input  loc_t    loc_b,
    input  square_t square,
    output letter_t first_cipher,
    output letter_t second_cipher,
    output logic    letter_missing
);

    function automatic pos_t next_pos(pos_t p);
        return (p == pos_t'(SQUARE_DIM - 1)) ? '0 : pos_t'(p + 3'd1);
    endfunction

    always_comb
    begin
        first_cipher   = '0;
        second_cipher  = '0;
        letter_missing = !(loc_a.found && loc_b.found);
        if (!letter_missing)
        begin
            if (loc_a.row == loc_b.row)
            begin
                first_cipher  = square[loc_a.row][next_pos(loc_a.col)];
                second_cipher = square[loc_b.row][next_pos(loc_b.col)];
            end
            else if (loc_a.col == loc_b.col)
            begin
                first_cipher  = square[next_pos(loc_a.row)][loc_a.col];
                second_cipher = square[next_pos(loc_b.row)][loc_b.col];
            end
            else
            begin
                first_cipher  = square[loc_a.row][loc_b.col];
                second_cipher = square[loc_b.row][loc_a.col];
            end
        end
    end

endmodule

// ===== hdl/playfair_digraph_encrypt.sv =====
// Playfair digraph encryption: two search lanes, a merge stage, output register.
// An accepted request is held in stage 1, then merged into the output register.
// Throughput: one letter pair per cycle while out_stall is low; the two-stage pipeline
// is set by the lane compare stage and the merge stage, each closed by a register.
// Reset clears both valid flags and loads the standard A..Z (no J) key square.
module playfair_digraph_encrypt
    import pfde_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_data,
    input  logic       cfg_we,
    input  reg_index_t cfg_index,
    input  row_t       cfg_data
);

    row_t    rows_reg [SQUARE_DIM];
    square_t square;

    loc_t    lane_a_loc;
    loc_t    lane_b_loc;
    loc_t    s1_loc_a_reg;
    loc_t    s1_loc_b_reg;
    logic    s1_last_reg;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    out_t    out_data_reg;

    letter_t m_first;
    letter_t m_second;
    logic    m_missing;
    logic    in_accept;
    logic    s1_advance;

    always_comb
    begin
        for (int r = 0; r < SQUARE_DIM; r++)
        begin
            square[r] = rows_reg[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg[0] <= ROW_ZERO_RESET;
            rows_reg[1] <= ROW_ONE_RESET;
            rows_reg[2] <= ROW_TWO_RESET;
            rows_reg[3] <= ROW_THREE_RESET;
            rows_reg[4] <= ROW_FOUR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_ZERO:  rows_reg[0] <= cfg_data;
                REG_ROW_ONE:   rows_reg[1] <= cfg_data;
                REG_ROW_TWO:   rows_reg[2] <= cfg_data;
                REG_ROW_THREE: rows_reg[3] <= cfg_data;
                REG_ROW_FOUR:  rows_reg[4] <= cfg_data;
                default:       ;
            endcase
        end
    end

    pfde_lane u_lane_a
    (
        .letter (in_data.first_letter),
        .square (square),
        .loc    (lane_a_loc)
    );

    pfde_lane u_lane_b
    (
        .letter (in_data.second_letter),
        .square (square),
        .loc    (lane_b_loc)
    );

    // stage 1 moves on whenever the output register is empty or being drained
    assign s1_advance = !out_valid_reg || !out_stall;
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_loc_a_reg <= lane_a_loc;
            s1_loc_b_reg <= lane_b_loc;
            s1_last_reg  <= in_data.last_pair;
        end
    end

    pfde_merge u_merge
    (
        .loc_a          (s1_loc_a_reg),
        .loc_b          (s1_loc_b_reg),
        .square         (square),
        .first_cipher   (m_first),
        .second_cipher  (m_second),
        .letter_missing (m_missing)
    );

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_data_reg.first_cipher   <= m_first;
            out_data_reg.second_cipher  <= m_second;
            out_data_reg.letter_missing <= m_missing;
            out_data_reg.last_out       <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a missing letter always zeroes both cipher letters
    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.letter_missing |->
            out_data.first_cipher == '0 && out_data.second_cipher == '0)
        else $error("cipher letters not cleared on missing letter");

    // back-pressure only when stage 1 holds a request
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty stage 1");

    // an out-of-range first letter can never be found
    a_range_miss: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_data.first_letter > LETTER_MAX |=> !s1_loc_a_reg.found)
        else $error("out-of-range letter located");

    // a held result keeps stage 1 from emptying into it
    a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall && s1_valid_reg |=> s1_valid_reg)
        else $error("stage 1 request dropped under stall");

endmodule

// ===== test/tb.sv =====
// Testbench for playfair_digraph_encrypt: letter-pair predictor, paced stimulus, result checks.
`timescale 1ns / 1ps

module tb;
    import pfde_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;

    typedef row_t square_rows_t [SQUARE_DIM];
    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

    localparam square_rows_t DEFAULT_ROWS = '{ROW_ZERO_RESET, ROW_ONE_RESET, ROW_TWO_RESET,
                                              ROW_THREE_RESET, ROW_FOUR_RESET};
    localparam reg_index_t ROW_REGS [SQUARE_DIM] = '{REG_ROW_ZERO, REG_ROW_ONE, REG_ROW_TWO,
                                                     REG_ROW_THREE, REG_ROW_FOUR};

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_t        in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_t       out_data;
    logic       cfg_we    = 1'b0;
    reg_index_t cfg_index = REG_ROW_ZERO;
    row_t       cfg_data  = '0;

    square_rows_t key_rows;
    out_t         cipher_q [$];

    stall_mode_t stall_mode  = STALL_NONE;
    int          stall_pct   = 30;
    int          stall_phase = 0;
    bit          hold_req    = 1'b0;
    int          hold_left   = 0;

    int idle_cycles   = 0;
    int fail_count    = 0;
    int pairs_sent    = 0;
    int pairs_checked = 0;
    int missing_seen  = 0;
    int squares_used  = 1;
    int input_stalls  = 0;

    playfair_digraph_encrypt u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic letter_t cell_of(int r, int c);
        return key_rows[r][5*c +: 5];
    endfunction

    function automatic int step_pos(int p);
        return (p == SQUARE_DIM - 1) ? 0 : p + 1;
    endfunction

    // J is searched as I; the last match in row-major order wins
    function automatic loc_t find_letter(letter_t letter);
        loc_t    where;
        letter_t key;
        where = '0;
        key = (letter == LETTER_J) ? LETTER_I : letter;
        if (key > LETTER_MAX)
            return where;
        for (int r = 0; r < SQUARE_DIM; r++)
            for (int c = 0; c < SQUARE_DIM; c++)
                if (cell_of(r, c) == key)
                begin
                    where.found = 1'b1;
                    where.row   = pos_t'(r);
                    where.col   = pos_t'(c);
                end
        return where;
    endfunction

    function automatic out_t encrypt_pair(in_t req);
        out_t res;
        loc_t a;
        loc_t b;
        res = '0;
        a = find_letter(req.first_letter);
        b = find_letter(req.second_letter);
        res.last_out       = req.last_pair;
        res.letter_missing = !(a.found && b.found);
        if (a.found && b.found)
        begin
            // a doubled letter lands in the row case
            if (a.row == b.row)
            begin
                res.first_cipher  = cell_of(a.row, step_pos(a.col));
                res.second_cipher = cell_of(b.row, step_pos(b.col));
            end
            else if (a.col == b.col)
            begin
                res.first_cipher  = cell_of(step_pos(a.row), a.col);
                res.second_cipher = cell_of(step_pos(b.row), b.col);
            end
            else
            begin
                res.first_cipher  = cell_of(a.row, b.col);
                res.second_cipher = cell_of(b.row, a.col);
            end
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic letter_t ltr(byte ch);
        return letter_t'(ch - "A");
    endfunction

    // mostly letters that sit in the current square, some outside it, a few out of range
    function automatic letter_t pick_letter();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 6)
            return letter_t'($urandom_range(26, 31));
        if (sel < 40)
            return cell_of($urandom_range(0, SQUARE_DIM - 1), $urandom_range(0, SQUARE_DIM - 1));
        return letter_t'($urandom_range(0, LETTER_MAX));
    endfunction

    function automatic in_t random_pair();
        in_t req;
        req.first_letter  = pick_letter();
        req.second_letter = ($urandom_range(0, 9) == 0) ? req.first_letter : pick_letter();
        req.last_pair     = ($urandom_range(0, 7) == 0);
        return req;
    endfunction

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_pair(in_t req);
        in_data  = req;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            input_stalls++;
            @(posedge clk);
        end
        cipher_q.push_back(encrypt_pair(req));
        pairs_sent++;
        @(negedge clk);
    endtask

    task automatic send_letters(letter_t a, letter_t b, logic last);
        send_pair(in_t'{a, b, last});
    endtask

    task automatic pause_sender(int cycles);
        in_valid = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (cipher_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_random_run(int count);
        int burst;
        while (count > 0)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && count > 0; i++)
            begin
                send_pair(random_pair());
                count--;
            end
            // some bursts run straight into the next
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 6));
        end
    endtask

    task automatic pick_stalls();
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        stall_pct  = $urandom_range(10, 60);
    endtask

    task automatic write_row(reg_index_t index, row_t value);
        cfg_index = index;
        cfg_data  = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        if (index < NUM_REGS)
            key_rows[index] = value;
    endtask

    task automatic load_square(square_rows_t rows);
        wait_drained();
        foreach (rows[r])
            write_row(ROW_REGS[r], rows[r]);
        squares_used++;
    endtask

    // ---------------------------------------------------------------- receiver and checks

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_stall = 1'b1;
        end
        else
        begin
            stall_phase = (stall_phase + 1) % 7;
            case (stall_mode)
                STALL_RANDOM:   out_stall = ($urandom_range(0, 99) < stall_pct);
                STALL_PERIODIC: out_stall = (stall_phase < 3);
                default:        out_stall = 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin : check_cipher
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cipher_q.size() == 0)
            begin
                $error("result with no request pending: first_cipher %0d second_cipher %0d",
                       out_data.first_cipher, out_data.second_cipher);
                fail_count++;
            end
            else
            begin
                want = cipher_q.pop_front();
                pairs_checked++;
                if (want.letter_missing)
                    missing_seen++;
                if (out_data.first_cipher !== want.first_cipher)
                begin
                    $error("first_cipher: expected %0d, got %0d",
                           want.first_cipher, out_data.first_cipher);
                    fail_count++;
                end
                if (out_data.second_cipher !== want.second_cipher)
                begin
                    $error("second_cipher: expected %0d, got %0d",
                           want.second_cipher, out_data.second_cipher);
                    fail_count++;
                end
                if (out_data.letter_missing !== want.letter_missing)
                begin
                    $error("letter_missing: expected %0d, got %0d",
                           want.letter_missing, out_data.letter_missing);
                    fail_count++;
                end
                if (out_data.last_out !== want.last_out)
                begin
                    $error("last_out: expected %0d, got %0d", want.last_out, out_data.last_out);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("** playfair_digraph_encrypt: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // standard square after reset: every rule, J folding, range limits
    task automatic test_default_square();
        stall_mode = STALL_RANDOM;
        send_letters(ltr("A"), ltr("B"), 1'b0);      // same row
        send_letters(ltr("D"), ltr("E"), 1'b0);      // row wrap
        send_letters(ltr("A"), ltr("F"), 1'b0);      // same column
        send_letters(ltr("V"), ltr("A"), 1'b1);      // column wrap
        send_letters(ltr("A"), ltr("G"), 1'b0);      // rectangle
        send_letters(ltr("L"), ltr("L"), 1'b0);      // doubled letter
        send_letters(ltr("J"), ltr("A"), 1'b0);
        send_letters(ltr("A"), ltr("J"), 1'b1);
        send_letters(ltr("J"), ltr("J"), 1'b0);
        send_letters(letter_t'(26), ltr("A"), 1'b0);
        send_letters(ltr("A"), letter_t'(31), 1'b0);
        send_letters(ltr("A"), ltr("Z"), 1'b0);
        send_letters(ltr("Z"), ltr("A"), 1'b1);
        send_letters(letter_t'(31), letter_t'(31), 1'b1);
    endtask

    // duplicate cell, a J cell, raw values above Z
    task automatic test_odd_square();
        square_rows_t rows;
        rows = DEFAULT_ROWS;
        rows[0][4:0]   = LETTER_J;       // A gone; a J cell never matches
        rows[4][24:20] = ltr("B");       // second B, the later one is used
        rows[2][14:10] = letter_t'(31);  // N gone
        rows[3][19:15] = letter_t'(26);  // T gone
        load_square(rows);
        stall_mode = STALL_PERIODIC;
        send_letters(ltr("B"), ltr("Y"), 1'b0);
        send_letters(ltr("A"), ltr("B"), 1'b0);
        send_letters(ltr("I"), ltr("M"), 1'b0);
        send_letters(ltr("S"), ltr("U"), 1'b0);
        send_letters(ltr("M"), ltr("O"), 1'b1);
        send_letters(ltr("J"), ltr("K"), 1'b0);
        send_letters(ltr("T"), ltr("T"), 1'b0);
        send_random_run(40);
    endtask

    task automatic test_register_extremes();
        square_rows_t rows;
        foreach (rows[r])
            rows[r] = '0;
        load_square(rows);
        pick_stalls();
        send_letters(ltr("A"), ltr("A"), 1'b0);
        send_letters(ltr("A"), ltr("B"), 1'b1);
        send_random_run(30);
        foreach (rows[r])
            rows[r] = '1;
        load_square(rows);
        send_letters(ltr("Z"), ltr("Z"), 1'b0);
        send_random_run(30);
    endtask

    // writes to indexes past the last row must leave the square alone
    task automatic test_unused_indexes();
        load_square(DEFAULT_ROWS);
        for (int k = 1; k <= 3; k++)
            write_row(reg_index_t'(REG_ROW_FOUR + k), row_t'($urandom));
        pick_stalls();
        send_random_run(40);
    endtask

    task automatic test_random_squares();
        square_rows_t rows;
        letter_t      pool [25];
        letter_t      tmp;
        int           n;
        int           k;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase % 3 == 2)
            begin
                // raw contents: duplicates, J cells, values above Z
                foreach (rows[r])
                    rows[r] = row_t'($urandom);
            end
            else
            begin
                n = 0;
                for (int l = 0; l <= LETTER_MAX; l++)
                    if (letter_t'(l) != LETTER_J)
                    begin
                        pool[n] = letter_t'(l);
                        n++;
                    end
                for (int i = 24; i > 0; i--)
                begin
                    k = $urandom_range(0, i);
                    tmp     = pool[i];
                    pool[i] = pool[k];
                    pool[k] = tmp;
                end
                foreach (rows[r])
                    for (int c = 0; c < SQUARE_DIM; c++)
                        rows[r][5*c +: 5] = pool[5*r + c];
            end
            load_square(rows);
            pick_stalls();
            send_random_run(250);
        end
    endtask

    // receiver holds off while the sender keeps offering, then the sender waits for all
    task automatic test_backpressure();
        wait_drained();
        stall_mode = STALL_NONE;
        hold_req   = 1'b1;
        for (int i = 0; i < 60; i++)
            send_pair(random_pair());
        wait_drained();
        pick_stalls();
        send_random_run(40);
    endtask

    initial
    begin
        key_rows = DEFAULT_ROWS;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_default_square();
        test_odd_square();
        test_register_extremes();
        test_unused_indexes();
        test_random_squares();
        test_backpressure();

        stall_mode = STALL_NONE;
        wait_drained();
        $display("covered %0d letter pairs over %0d key squares, %0d results checked",
                 pairs_sent, squares_used, pairs_checked);
        $display("%0d results with a missing letter, %0d cycles of input stall",
                 missing_seen, input_stalls);
        if (fail_count == 0)
            $display("** playfair_digraph_encrypt: PASSED **");
        else
            $display("** playfair_digraph_encrypt: FAILED **");
        $finish;
    end

endmodule
